// ===== hdl/pot_pkg.sv =====
// pot_pkg: shared types and constants for the page ownership table
// used by pot_mem, pot_ctrl, page_ownership_table_core and pot_checker
// no dependencies
package pot_pkg;

	localparam int MAX_PAGES  = 64;
	localparam int STATE_BITS = 16;
	localparam int PAGE_AW    = $clog2(MAX_PAGES);
	localparam int NP_W       = 7;
	localparam int CNT_W      = 7;
	localparam int SVAL_W     = 15;

	localparam logic [STATE_BITS-1:0] RESET_WORD = STATE_BITS'(1);

	typedef enum logic [2:0] {
		OP_FIND_FREE  = 3'd0,
		OP_FIND_DATA  = 3'd1,
		OP_FIND_STATE = 3'd2,
		OP_SET_STATE  = 3'd3,
		OP_FREE       = 3'd4,
		OP_SEND_DATA  = 3'd5,
		OP_SEND_FREE  = 3'd6,
		OP_COUNT      = 3'd7
	} req_op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_INVALID   = 2'd1,
		STS_NOT_OWNER = 2'd2,
		STS_NONE      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK
	} ctrl_state_t;

	typedef struct packed {
		logic                  rd_en;
		logic [PAGE_AW-1:0]    rd_addr;
		logic                  wr_en;
		logic [PAGE_AW-1:0]    wr_addr;
		logic [STATE_BITS-1:0] wr_data;
	} mem_req_t;

endpackage

// ===== hdl/pot_mem.sv =====
// pot_mem: page state memory, one read and one write port, registered read
// entries never written read as the reset word (free, owned by server)
// depends on pot_pkg
module pot_mem
	import pot_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  mem_req_t              req,
	output logic [STATE_BITS-1:0] rd_word
);

	logic [STATE_BITS-1:0] mem_q [MAX_PAGES];
	logic [MAX_PAGES-1:0]  valid_q;
	logic [STATE_BITS-1:0] rd_data_s1;
	logic                  rd_vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_s1 <= mem_q[req.rd_addr];
			rd_vld_s1  <= valid_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	assign rd_word = rd_vld_s1 ? rd_data_s1 : RESET_WORD;

endmodule

// ===== hdl/pot_ctrl.sv =====
// pot_ctrl: request sequencer; scans the memory one entry a cycle for finds
// and counts, does read-check-write for single page operations
// depends on pot_pkg
module pot_ctrl
	import pot_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            req_type,
	input  logic                  requester_is_server,
	input  logic [NP_W-1:0]       page_number,
	input  logic [NP_W-1:0]       start_page,
	input  logic [SVAL_W-1:0]     state_value,
	input  logic [NP_W-1:0]       n_active,
	output mem_req_t              mem_req,
	input  logic [STATE_BITS-1:0] rd_word,
	output logic                  done,
	output logic [1:0]            status,
	output logic [PAGE_AW-1:0]    found_page,
	output logic [CNT_W-1:0]      owned_count,
	output logic                  notify
);

	ctrl_state_t state_q, state_d;

	req_op_t               op_q;
	logic                  srv_q;
	logic [PAGE_AW-1:0]    page_q;
	logic [SVAL_W-1:0]     sval_q;
	logic [NP_W-1:0]       addr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PAGE_AW-1:0]    ridx_s1;
	logic                  rv_s1;

	logic                  done_q;
	status_t               status_q;
	logic [PAGE_AW-1:0]    found_q;
	logic [CNT_W-1:0]      count_q;
	logic                  notify_q;

	req_op_t               in_op;
	logic                  acc, in_single, in_page_ok;
	logic                  w_pos, owned, w_one, w_data, w_match, hit;
	logic                  scan_more, issue, finish;
	logic [STATE_BITS-1:0] sval_ext, sval_neg, new_word;
	status_t               res_status;
	logic [PAGE_AW-1:0]    res_found;
	logic [CNT_W-1:0]      res_count;
	logic                  res_notify;

	assign in_op      = req_op_t'(req_type);
	assign acc        = start && (state_q == ST_IDLE);
	assign in_single  = (in_op == OP_SET_STATE) || (in_op == OP_FREE) ||
			    (in_op == OP_SEND_DATA) || (in_op == OP_SEND_FREE);
	assign in_page_ok = page_number < n_active;

	// classify the word coming back from the memory
	assign w_pos    = !rd_word[STATE_BITS-1] && (|rd_word);
	assign owned    = (w_pos == srv_q);
	assign w_one    = (rd_word == RESET_WORD) || (rd_word == '1);
	assign w_data   = (|rd_word) && !w_one;
	assign sval_ext = STATE_BITS'(sval_q);
	assign sval_neg = -sval_ext;

	always_comb begin
		case (op_q)
			OP_FIND_FREE:  w_match = w_one;
			OP_FIND_DATA:  w_match = w_data;
			OP_FIND_STATE: w_match = (rd_word == sval_ext) || (rd_word == sval_neg);
			default:       w_match = 1'b0;
		endcase
	end

	assign hit       = (state_q == ST_SCAN) && rv_s1 && owned && w_match;
	assign scan_more = addr_q < n_active;
	assign issue     = (state_q == ST_SCAN) && scan_more && !hit;

	always_comb begin
		case (op_q)
			OP_SET_STATE: new_word = srv_q ? sval_ext : sval_neg;
			OP_FREE:      new_word = srv_q ? RESET_WORD : '1;
			OP_SEND_DATA: new_word = srv_q ? -STATE_BITS'(2) : STATE_BITS'(2);
			default:      new_word = srv_q ? '1 : RESET_WORD;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (!in_single) begin
						state_d = ST_SCAN;
					end else if (in_page_ok) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_SCAN: begin
				if (hit || (!scan_more && !rv_s1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: memory port and result beat
	always_comb begin
		mem_req    = '0;
		finish     = 1'b0;
		res_status = STS_OK;
		res_found  = '0;
		res_count  = '0;
		res_notify = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mem_req.rd_en   = acc && in_single && in_page_ok;
				mem_req.rd_addr = page_number[PAGE_AW-1:0];
				if (acc && in_single && !in_page_ok) begin
					finish     = 1'b1;
					res_status = STS_INVALID;
				end
			end
			ST_SCAN: begin
				mem_req.rd_en   = issue;
				mem_req.rd_addr = addr_q[PAGE_AW-1:0];
				finish          = hit || (!scan_more && !rv_s1);
				if (op_q == OP_COUNT) begin
					res_count = cnt_q;
				end else if (hit) begin
					res_found = ridx_s1;
				end else begin
					res_status = STS_NONE;
				end
			end
			ST_CHECK: begin
				finish          = 1'b1;
				mem_req.wr_en   = owned;
				mem_req.wr_addr = page_q;
				mem_req.wr_data = new_word;
				if (owned) begin
					res_notify = (op_q == OP_SEND_DATA) || (op_q == OP_SEND_FREE);
				end else begin
					res_status = STS_NOT_OWNER;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= issue;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= in_op;
			srv_q  <= requester_is_server;
			page_q <= page_number[PAGE_AW-1:0];
			sval_q <= state_value;
			addr_q <= (in_op == OP_COUNT) ? '0 : start_page;
			cnt_q  <= '0;
		end else begin
			if (issue) begin
				addr_q <= addr_q + NP_W'(1);
			end
			if ((state_q == ST_SCAN) && rv_s1 && owned) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
		if (issue) begin
			ridx_s1 <= addr_q[PAGE_AW-1:0];
		end
		if (finish) begin
			status_q <= res_status;
			found_q  <= res_found;
			count_q  <= res_count;
			notify_q <= res_notify;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_page  = found_q;
	assign owned_count = count_q;
	assign notify      = notify_q;

endmodule

// ===== hdl/page_ownership_table_core.sv =====
// page ownership table: page count register, request sequencer, state memory
// finds stop at the first hit; misses and counts scan on to the last active page
// set, free, send: read, ownership check, then write if owned
// an out-of-range page is rejected at accept without going busy; else busy until finished
// one request at a time, one memory entry read per cycle on the single read port
// reset: all pages free to server, page count 64; the result receiver cannot stall
module page_ownership_table_core
	import pot_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        req_type,
	input  logic              requester_is_server,
	input  logic [NP_W-1:0]   page_number,
	input  logic [NP_W-1:0]   start_page,
	input  logic [SVAL_W-1:0] state_value,
	input  logic              cfg_wr_en,
	input  logic [NP_W-1:0]   cfg_wr_data,
	output logic              done,
	output logic [1:0]        status,
	output logic [PAGE_AW-1:0] found_page,
	output logic [CNT_W-1:0]  owned_count,
	output logic              notify
);

	logic [NP_W-1:0]       num_pages_q;
	logic [NP_W-1:0]       n_active;
	mem_req_t              mem_req;
	logic [STATE_BITS-1:0] rd_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_pages_q <= NP_W'(64);
		end else if (cfg_wr_en) begin
			num_pages_q <= cfg_wr_data;
		end
	end

	// page count saturates at the table depth
	assign n_active = (num_pages_q > NP_W'(MAX_PAGES)) ? NP_W'(MAX_PAGES) : num_pages_q;

	pot_ctrl u_ctrl (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.req_type            (req_type),
		.requester_is_server (requester_is_server),
		.page_number         (page_number),
		.start_page          (start_page),
		.state_value         (state_value),
		.n_active            (n_active),
		.mem_req             (mem_req),
		.rd_word             (rd_word),
		.done                (done),
		.status              (status),
		.found_page          (found_page),
		.owned_count         (owned_count),
		.notify              (notify)
	);

	pot_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_word (rd_word)
	);

endmodule

// ===== hdl/pot_checker.sv =====
// pot_checker: port-level checks on the page ownership table result beats
// bound to page_ownership_table_core; depends on pot_pkg
module pot_checker
	import pot_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic [PAGE_AW-1:0] found_page,
	input logic [CNT_W-1:0]   owned_count,
	input logic               notify
);

	// a result beat always follows an accepted request or ongoing work
	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start) || $past(busy)))
		else $error("result beat without a request");

	// notify only with ok status, no found page and no count
	a_notify_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && notify) |-> (status == STS_OK && owned_count == '0 && found_page == '0))
		else $error("notify with failed status");

	// failed requests carry no found page and no count
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STS_OK) |-> (found_page == '0 && owned_count == '0 && !notify))
		else $error("failed request with payload");

	// count never exceeds the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (owned_count <= CNT_W'(MAX_PAGES)))
		else $error("owned count beyond table depth");

endmodule

bind page_ownership_table_core pot_checker u_pot_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.found_page  (found_page),
	.owned_count (owned_count),
	.notify      (notify)
);
